@@ design/mchm_pkg.sv @@
package mchm_pkg;

    localparam int SLOPE_W            = 32;
    localparam int ICPT_W             = 63;
    localparam int X_W                = 32;
    localparam int ENTRY_W            = SLOPE_W + ICPT_W;
    localparam int PROD_W             = SLOPE_W + X_W;
    localparam int VAL_W              = PROD_W + 1;   // exact line value, carry included
    localparam int MAG_W              = ICPT_W + SLOPE_W;
    localparam int DEFAULT_HULL_DEPTH = 1024;

    typedef struct packed {
        logic [SLOPE_W-1:0] slope;
        logic [ICPT_W-1:0]  intercept;
        logic [X_W-1:0]     query_x;
    } t_in_item;

    typedef struct packed {
        logic [ICPT_W-1:0] min_value;
        logic              hull_overflow;
    } t_out_item;

    // one stored hull line, also the RAM word layout
    typedef struct packed {
        logic [SLOPE_W-1:0] slope;
        logic [ICPT_W-1:0]  intercept;
    } t_line;

    typedef struct packed {
        logic done;
        logic useless;
    } t_pop_res;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] value;
    } t_eval_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_POP_START,
        ST_POP_WAIT,
        ST_PUSH,
        ST_Q_RD,
        ST_Q_EV0,
        ST_Q_W0,
        ST_Q_EV1,
        ST_Q_W1,
        ST_OUT
    } t_state;

endpackage

@@ design/monotone_convex_hull_min_unit.sv @@
// Monotone convex hull trick, minimum queries. Each item brings a line
// (slope, intercept) and a query position; slopes must be non-increasing and
// queries non-decreasing across items. The line is appended to a lower hull
// kept in one synchronous RAM of HULL_DEPTH entries, after popping back lines
// that fail the exact three-line test; then a monotone pointer walks forward
// while the next line is strictly lower at query_x, and the value of the
// pointed line is returned, saturated to 63 bits. A full hull drops the line
// and flags hull_overflow; the query still runs. One item is worked at a
// time. Each three-line test (one per pop, plus one when a test keeps the
// back line) is bound by the RAM read and a five-stage exact cross-product
// compare; each line evaluation (one per pointer step, one for the pointed
// line, plus one when a next line exists) by the RAM read and a
// multiply-add. A dropped line skips the push. No clearing pass after
// reset: only entries below the fill count are read.
module monotone_convex_hull_min_unit
    import mchm_pkg::*;
#(
    parameter int HULL_DEPTH = DEFAULT_HULL_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int ADDR_W = (HULL_DEPTH > 1) ? $clog2(HULL_DEPTH) : 1;
    localparam int CNT_W  = $clog2(HULL_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(HULL_DEPTH);
    localparam logic [CNT_W-1:0] TWO  = CNT_W'(2);

    // control state
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;   // hull fill count
    logic [ADDR_W-1:0] r_ptr, n_ptr;      // best line pointer
    logic             r_out_valid, n_out_valid;

    // item payload and working values
    t_line            r_cur, n_cur;       // incoming line
    logic [X_W-1:0]   r_x, n_x;
    logic             r_ovf, n_ovf;
    t_line            r_top, n_top;       // cached last hull entry (line b)
    t_line            r_a, n_a;           // second-to-last entry, read from RAM
    logic [VAL_W-1:0] r_v0, n_v0;         // value of pointed line
    t_out_item        r_out_item, n_out_item;

    // RAM port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_line             rd_line;

    logic      pop_start, ev_start;
    t_pop_res  pop_res;
    t_eval_res ev_res;

    logic             in_acc;
    logic [CNT_W-1:0] cnt_m1, cnt_m2, ptr_ext, ptr_nx, ptr_nx2;
    logic [ICPT_W-1:0] sat_val;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign rd_line = t_line'(ram_rdata);
    assign cnt_m1  = r_count - CNT_W'(1);
    assign cnt_m2  = r_count - TWO;
    assign ptr_ext = CNT_W'(r_ptr);
    assign ptr_nx  = ptr_ext + CNT_W'(1);
    assign ptr_nx2 = ptr_ext + TWO;
    // a carry above 63 bits saturates
    assign sat_val = (r_v0[VAL_W-1:ICPT_W] != '0) ? '1 : r_v0[ICPT_W-1:0];

    mchm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HULL_DEPTH)
    ) u_hull_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ENTRY_W'(r_cur)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // a = second-to-last line (RAM), b = last line (cached), n = new line
    mchm_hull_test u_hull_test (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (pop_start),
        .i_a     (rd_line),
        .i_b     (r_top),
        .i_n     (r_cur),
        .o_res   (pop_res)
    );

    mchm_line_eval u_line_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ev_start),
        .i_line  (rd_line),
        .i_x     (r_x),
        .o_res   (ev_res)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_cur       = r_cur;
        n_x         = r_x;
        n_ovf       = r_ovf;
        n_top       = r_top;
        n_a         = r_a;
        n_v0        = r_v0;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_waddr   = r_count[ADDR_W-1:0];
        ram_raddr   = r_ptr;
        pop_start   = 1'b0;
        ev_start    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_cur.slope     = i_in_item.slope;
                    n_cur.intercept = i_in_item.intercept;
                    n_x             = i_in_item.query_x;
                    if (r_count >= FULL) begin
                        // full hull: drop the line, still answer the query
                        n_ovf   = 1'b1;
                        n_state = ST_Q_RD;
                    end else begin
                        n_ovf   = 1'b0;
                        n_state = (r_count >= TWO) ? ST_POP_RD : ST_PUSH;
                    end
                end
            end
            ST_POP_RD: begin
                ram_raddr = cnt_m2[ADDR_W-1:0];
                n_state   = ST_POP_START;
            end
            ST_POP_START: begin
                pop_start = 1'b1;
                n_a       = rd_line;
                n_state   = ST_POP_WAIT;
            end
            ST_POP_WAIT: begin
                if (pop_res.done) begin
                    if (pop_res.useless) begin
                        // drop line b; line a becomes the new back
                        n_count = cnt_m1;
                        n_top   = r_a;
                        n_state = (cnt_m1 >= TWO) ? ST_POP_RD : ST_PUSH;
                    end else begin
                        n_state = ST_PUSH;
                    end
                end
            end
            ST_PUSH: begin
                ram_we  = 1'b1;
                n_count = r_count + CNT_W'(1);
                n_top   = r_cur;
                n_state = ST_Q_RD;
            end
            ST_Q_RD: begin
                if (r_count == '0) begin
                    n_v0    = '0;
                    n_state = ST_OUT;
                end else begin
                    // clamp pointer to the back after pops
                    if (ptr_ext > cnt_m1) begin
                        n_ptr = cnt_m1[ADDR_W-1:0];
                    end
                    ram_raddr = n_ptr;
                    n_state   = ST_Q_EV0;
                end
            end
            ST_Q_EV0: begin
                ev_start = 1'b1;
                n_state  = ST_Q_W0;
            end
            ST_Q_W0: begin
                if (ev_res.done) begin
                    n_v0 = ev_res.value;
                    if (ptr_nx < r_count) begin
                        ram_raddr = ptr_nx[ADDR_W-1:0];
                        n_state   = ST_Q_EV1;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_Q_EV1: begin
                ev_start = 1'b1;
                n_state  = ST_Q_W1;
            end
            ST_Q_W1: begin
                if (ev_res.done) begin
                    if (r_v0 > ev_res.value) begin
                        // next line strictly lower: advance
                        n_ptr = ptr_nx[ADDR_W-1:0];
                        n_v0  = ev_res.value;
                        if (ptr_nx < cnt_m1) begin
                            ram_raddr = ptr_nx2[ADDR_W-1:0];
                            n_state   = ST_Q_EV1;
                        end else begin
                            n_state = ST_OUT;
                        end
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid              = 1'b1;
                    n_out_item.min_value     = sat_val;
                    n_out_item.hull_overflow = r_ovf;
                    n_state                  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_x        <= n_x;
        r_ovf      <= n_ovf;
        r_top      <= n_top;
        r_a        <= n_a;
        r_v0       <= n_v0;
        r_out_item <= n_out_item;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    // fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("hull count above depth");

    // the best line pointer lies inside the hull while lines are evaluated
    a_ptr_in_hull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_Q_EV0 || r_state == ST_Q_EV1) |-> (ptr_nx <= r_count))
        else $error("pointer outside hull");

    // overflow only reported with a full hull
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_ovf) |-> (r_count == FULL))
        else $error("overflow without full hull");

    // a pop always leaves at least one line
    a_pop_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP_WAIT && pop_res.done && pop_res.useless)
            |=> (r_count >= CNT_W'(1)))
        else $error("pop emptied hull");
`endif

endmodule

@@ design/mchm_ram.sv @@
module mchm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ design/mchm_hull_test.sv @@
// Three-line test: is middle line b useless between a and new line n?
// (n.c - a.c)*(a.m - b.m) <= (b.c - a.c)*(a.m - n.m), exact, signed.
// Five stages: differences, low partial products, high partial products,
// sums, compare.
module mchm_hull_test
    import mchm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_line    i_a,
    input  t_line    i_b,
    input  t_line    i_n,
    output t_pop_res o_res
);

    localparam int HI_W = ICPT_W - 32;

    logic [4:0]              r_vld;
    logic [ICPT_W-1:0]       r_d1, r_d3;
    logic [SLOPE_W-1:0]      r_d2, r_d4;
    logic                    r_n1, r_n2;
    logic [63:0]             r_pl1, r_pl2;
    logic [HI_W+SLOPE_W-1:0] r_ph1, r_ph2;
    logic [MAG_W-1:0]        r_mag1, r_mag2;
    logic                    r_useless;

    logic s1, s2, s3, s4;
    logic neg1, neg2, lt, eq;

    assign s1 = i_n.intercept < i_a.intercept;
    assign s2 = i_a.slope < i_b.slope;
    assign s3 = i_b.intercept < i_a.intercept;
    assign s4 = i_a.slope < i_n.slope;

    assign neg1 = r_n1 && (r_mag1 != '0);
    assign neg2 = r_n2 && (r_mag2 != '0);
    assign lt   = r_mag1 < r_mag2;
    assign eq   = r_mag1 == r_mag2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d1 <= s1 ? (i_a.intercept - i_n.intercept) : (i_n.intercept - i_a.intercept);
            r_d2 <= s2 ? (i_b.slope - i_a.slope) : (i_a.slope - i_b.slope);
            r_d3 <= s3 ? (i_a.intercept - i_b.intercept) : (i_b.intercept - i_a.intercept);
            r_d4 <= s4 ? (i_n.slope - i_a.slope) : (i_a.slope - i_n.slope);
            r_n1 <= s1 ^ s2;
            r_n2 <= s3 ^ s4;
        end
        if (r_vld[0]) begin
            r_pl1 <= 64'(r_d1[31:0]) * 64'(r_d2);
            r_pl2 <= 64'(r_d3[31:0]) * 64'(r_d4);
        end
        if (r_vld[1]) begin
            r_ph1 <= (HI_W+SLOPE_W)'(r_d1[ICPT_W-1:32]) * (HI_W+SLOPE_W)'(r_d2);
            r_ph2 <= (HI_W+SLOPE_W)'(r_d3[ICPT_W-1:32]) * (HI_W+SLOPE_W)'(r_d4);
        end
        if (r_vld[2]) begin
            r_mag1 <= {r_ph1, 32'b0} + MAG_W'(r_pl1);
            r_mag2 <= {r_ph2, 32'b0} + MAG_W'(r_pl2);
        end
        if (r_vld[3]) begin
            // useless when signed product1 <= signed product2
            r_useless <= (neg1 != neg2) ? neg1 : (eq || (lt ^ neg1));
        end
    end

    assign o_res.done    = r_vld[4];
    assign o_res.useless = r_useless;

endmodule

@@ design/mchm_line_eval.sv @@
// Exact line value slope*x + intercept, two stages.
module mchm_line_eval
    import mchm_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  t_line          i_line,
    input  logic [X_W-1:0] i_x,
    output t_eval_res      o_res
);

    logic [1:0]        r_vld;
    logic [PROD_W-1:0] r_prod;
    logic [ICPT_W-1:0] r_icpt;
    logic [VAL_W-1:0]  r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PROD_W'(i_line.slope) * PROD_W'(i_x);
            r_icpt <= i_line.intercept;
        end
        if (r_vld[0]) begin
            r_val <= VAL_W'(r_prod) + VAL_W'(r_icpt);
        end
    end

    assign o_res.done  = r_vld[1];
    assign o_res.value = r_val;

endmodule
